[src/mpts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multilevel priority task scheduler package
// Shared types, operation and status codes, and the priority to class map.
// ----------------------------------------------------------------------------
package mpts_pkg;

	// Number of priority classes, fixed by the scheme.
	localparam int NUM_CLASSES = 6;
	localparam int CLASS_W     = 3;
	localparam int QUANTUM_W   = 16;
	localparam int OUT_ID_W    = 8;
	localparam int CFG_IDX_W   = 3;

	typedef logic [CLASS_W-1:0]   cls_t;
	typedef logic [1:0]           status_t;
	typedef logic [1:0]           opcode_t;
	typedef logic [QUANTUM_W-1:0] quantum_t;

	// Operation codes carried in a request beat.
	localparam opcode_t OP_ENQUEUE  = 2'd0;
	localparam opcode_t OP_BOOST    = 2'd1;
	localparam opcode_t OP_DISPATCH = 2'd2;

	// Result status codes.
	localparam status_t ST_ENQUEUED   = 2'd0;
	localparam status_t ST_DISPATCHED = 2'd1;
	localparam status_t ST_EMPTY      = 2'd2;
	localparam status_t ST_FULL       = 2'd3;

	// Quantum reset values, one per class.
	localparam quantum_t QUANTUM_RESET [NUM_CLASSES] = '{
		16'd4, 16'd6, 16'd8, 16'd10, 16'd12, 16'd20
	};

	// Outcome of one request, handed from the queue control to the result stage.
	typedef struct packed {
		logic    has_result;
		logic    pop;
		status_t status;
		cls_t    cls;
	} result_t;

	// Map a task priority number onto its class.
	function automatic cls_t class_of(input logic [3:0] p);
		cls_t c;
		priority if (p <= 4'd1) begin
			c = 3'd0;
		end else if (p == 4'd2) begin
			c = 3'd1;
		end else if (p == 4'd3) begin
			c = 3'd2;
		end else if (p <= 4'd5) begin
			c = 3'd3;
		end else if (p <= 4'd8) begin
			c = 3'd4;
		end else begin
			c = 3'd5;
		end
		return c;
	endfunction

endpackage

[src/mpts_queue_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue storage
// Single-port synchronous memory holding the task ids of all class queues.
// ----------------------------------------------------------------------------
module mpts_queue_mem #(
	parameter int ADDR_W = 7,
	parameter int DATA_W = 8,
	parameter int DEPTH  = 96
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [0:DEPTH-1];
	logic [DATA_W-1:0] rdata_q;

	// One access a cycle; read data is registered and held until the next read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/mpts_queue_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue control
// Head, tail and fill count per class; picks the class for each request and
// drives the storage address.
// ----------------------------------------------------------------------------
module mpts_queue_ctrl #(
	parameter int QUEUE_DEPTH = 16,
	parameter int PTR_W       = 4,
	parameter int ADDR_W      = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  mpts_pkg::opcode_t     opcode,
	input  logic [3:0]            task_priority,
	output logic                  mem_we,
	output logic                  mem_re,
	output logic [ADDR_W-1:0]     mem_addr,
	output mpts_pkg::result_t     result
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [PTR_W-1:0] head_q [mpts_pkg::NUM_CLASSES];
	logic [PTR_W-1:0] tail_q [mpts_pkg::NUM_CLASSES];
	logic [CNT_W-1:0] cnt_q  [mpts_pkg::NUM_CLASSES];

	logic [mpts_pkg::NUM_CLASSES-1:0] nonempty;
	mpts_pkg::cls_t enq_cls;
	mpts_pkg::cls_t pick_cls;
	mpts_pkg::cls_t cls_sel;
	logic           is_enq;
	logic           is_disp;
	logic           any;
	logic           full;
	logic           do_push;
	logic           do_pop;
	logic [PTR_W-1:0] ptr_sel;

	// Enqueue class, with the one-step boost for I/O completion.
	always_comb begin
		enq_cls = mpts_pkg::class_of(task_priority);
		if (opcode == mpts_pkg::OP_BOOST && enq_cls != 3'd0) begin
			enq_cls = enq_cls - 3'd1;
		end
	end

	// Most urgent nonempty class.
	always_comb begin
		pick_cls = '0;
		for (int c = mpts_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
			nonempty[c] = (cnt_q[c] != '0);
			if (nonempty[c]) begin
				pick_cls = mpts_pkg::cls_t'(c);
			end
		end
	end

	assign is_enq  = (opcode == mpts_pkg::OP_ENQUEUE) || (opcode == mpts_pkg::OP_BOOST);
	assign is_disp = (opcode == mpts_pkg::OP_DISPATCH);
	assign any     = |nonempty;
	assign cls_sel = is_disp ? pick_cls : enq_cls;
	assign full    = (cnt_q[cls_sel] == CNT_W'(QUEUE_DEPTH));
	assign do_push = accept && is_enq && !full;
	assign do_pop  = accept && is_disp && any;
	assign ptr_sel = is_disp ? head_q[cls_sel] : tail_q[cls_sel];

	// Storage access for this request.
	assign mem_we   = do_push;
	assign mem_re   = do_pop;
	assign mem_addr = {cls_sel, ptr_sel};

	// Result of this request.
	always_comb begin
		result.has_result = accept && (is_enq || is_disp);
		result.pop        = do_pop;
		result.cls        = cls_sel;
		if (is_disp) begin
			result.status = any ? mpts_pkg::ST_DISPATCHED : mpts_pkg::ST_EMPTY;
			if (!any) begin
				result.cls = '0;
			end
		end else begin
			result.status = full ? mpts_pkg::ST_FULL : mpts_pkg::ST_ENQUEUED;
		end
	end

	// Pointer and count update; a pointer wraps after the last slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < mpts_pkg::NUM_CLASSES; c++) begin
				head_q[c] <= '0;
				tail_q[c] <= '0;
				cnt_q[c]  <= '0;
			end
		end else if (do_push) begin
			tail_q[cls_sel] <= (tail_q[cls_sel] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
				tail_q[cls_sel] + PTR_W'(1);
			cnt_q[cls_sel]  <= cnt_q[cls_sel] + CNT_W'(1);
		end else if (do_pop) begin
			head_q[cls_sel] <= (head_q[cls_sel] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
				head_q[cls_sel] + PTR_W'(1);
			cnt_q[cls_sel]  <= cnt_q[cls_sel] - CNT_W'(1);
		end
	end

endmodule

[src/multilevel_priority_task_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multilevel priority task scheduler
// Six FIFO task queues, one per priority class, in one synchronous memory.
// The result beat is presented in the cycle after the request beat is taken.
// Throughput: one request per cycle while no stalled result beat is waiting, set by the single storage port.
// Reset: pointers and counts clear at once; quanta return to their defaults.
// There is no clearing pass: queue entries are only read after being written.
// ----------------------------------------------------------------------------
module multilevel_priority_task_scheduler #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Request channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     opcode,
	input  logic [7:0]                     task_id,
	input  logic [3:0]                     task_priority,
	// Result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [7:0]                     picked_id,
	output logic [2:0]                     picked_class,
	output logic [15:0]                    slice_ms,
	// Configuration channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mpts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data
);

	localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int ADDR_W = mpts_pkg::CLASS_W + PTR_W;
	localparam int DEPTH  = mpts_pkg::NUM_CLASSES << PTR_W;

	mpts_pkg::quantum_t quanta_q [mpts_pkg::NUM_CLASSES];

	logic              in_fire;
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_addr;
	logic [15:0]       id_wide;
	logic [ID_WIDTH-1:0] mem_rdata;
	logic [15:0]       rd_wide;
	mpts_pkg::result_t result;

	logic               v_s1;
	logic               pop_s1;
	mpts_pkg::status_t  status_s1;
	mpts_pkg::cls_t     cls_s1;
	mpts_pkg::quantum_t slice_s1;

	// A request beat is taken unless a result beat is waiting and stalled.
	assign in_stall  = v_s1 && out_stall;
	assign in_fire   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Quantum registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < mpts_pkg::NUM_CLASSES; c++) begin
				quanta_q[c] <= mpts_pkg::QUANTUM_RESET[c];
			end
		end else if (cfg_valid && cfg_ready &&
				cfg_index < mpts_pkg::CFG_IDX_W'(mpts_pkg::NUM_CLASSES)) begin
			quanta_q[cfg_index] <= cfg_data;
		end
	end

	mpts_queue_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.PTR_W       (PTR_W),
		.ADDR_W      (ADDR_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (in_fire),
		.opcode        (opcode),
		.task_priority (task_priority),
		.mem_we        (mem_we),
		.mem_re        (mem_re),
		.mem_addr      (mem_addr),
		.result        (result)
	);

	// Ids are stored at ID_WIDTH bits.
	assign id_wide = 16'(task_id);

	mpts_queue_mem #(
		.ADDR_W (ADDR_W),
		.DATA_W (ID_WIDTH),
		.DEPTH  (DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (id_wide[ID_WIDTH-1:0]),
		.rdata (mem_rdata)
	);

	// Result stage: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire) begin
			v_s1 <= result.has_result;
		end else if (!out_stall) begin
			v_s1 <= 1'b0;
		end
	end

	// Result stage: payload, the id itself arrives from the memory read.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pop_s1    <= result.pop;
			status_s1 <= result.status;
			cls_s1    <= result.cls;
			slice_s1  <= result.pop ? quanta_q[result.cls] : '0;
		end
	end

	assign rd_wide = 16'(mem_rdata);

	// Result beat.
	assign out_valid    = v_s1;
	assign status       = status_s1;
	assign picked_class = cls_s1;
	assign slice_ms     = slice_s1;
	assign picked_id    = pop_s1 ? rd_wide[mpts_pkg::OUT_ID_W-1:0] : '0;

endmodule

[tb/tb_multilevel_priority_task_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the multilevel priority task scheduler
// Drives enqueue, boosted enqueue, dispatch and unused request beats through
// the request channel and keeps its own model of the six class FIFOs and the
// quanta. Every result beat is checked field by field against the oldest
// outstanding prediction. The sender works in bursts and the receiver stalls
// on its own pattern. The quanta are rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb_multilevel_priority_task_scheduler;

	localparam int FIFO_DEPTH   = 16;
	localparam int DRAIN_CYCLES = 4;
	localparam int CYCLE_LIMIT  = 200000;

	// Request code with no meaning: the block must ignore it.
	localparam mpts_pkg::opcode_t OP_UNUSED = 2'd3;

	// Configuration register indexes.
	localparam logic [mpts_pkg::CFG_IDX_W-1:0] REG_QUANTUM_REALTIME = 3'd0;
	localparam logic [mpts_pkg::CFG_IDX_W-1:0] REG_RESERVED_LO      = 3'd6;
	localparam logic [mpts_pkg::CFG_IDX_W-1:0] REG_RESERVED_HI      = 3'd7;

	// Fixed stall sequence for the receiver's pattern mode.
	localparam logic [15:0] STALL_PATTERN_BITS = 16'b0110_0011_1000_0101;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HEAVY} stall_mode_t;
	typedef enum int {GAP_NONE, GAP_BURSTY} gap_mode_t;
	typedef enum int {QSET_ZERO, QSET_MAX, QSET_RANDOM, QSET_ALTERNATE} quanta_set_t;

	typedef struct packed {
		mpts_pkg::status_t  status;
		logic [7:0]         id;
		mpts_pkg::cls_t     cls;
		mpts_pkg::quantum_t slice;
	} sched_result_t;

	logic                           clk;
	logic                           arst_n        = 1'b0;
	logic                           in_valid      = 1'b0;
	logic                           in_stall;
	mpts_pkg::opcode_t              opcode        = mpts_pkg::OP_ENQUEUE;
	logic [7:0]                     task_id       = 8'd0;
	logic [3:0]                     task_priority = 4'd0;
	logic                           out_valid;
	logic                           out_stall     = 1'b0;
	logic [1:0]                     status;
	logic [7:0]                     picked_id;
	logic [2:0]                     picked_class;
	logic [15:0]                    slice_ms;
	logic                           cfg_valid     = 1'b0;
	logic                           cfg_ready;
	logic [mpts_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
	logic [15:0]                    cfg_data      = 16'd0;

	// Model state: one FIFO per class and the current quanta.
	logic [7:0]         class_fifo [mpts_pkg::NUM_CLASSES][FIFO_DEPTH];
	int                 fifo_head  [mpts_pkg::NUM_CLASSES] = '{default: 0};
	int                 fifo_tail  [mpts_pkg::NUM_CLASSES] = '{default: 0};
	int                 fifo_fill  [mpts_pkg::NUM_CLASSES] = '{default: 0};
	mpts_pkg::quantum_t quantum_cfg [mpts_pkg::NUM_CLASSES] = '{
		16'd4, 16'd6, 16'd8, 16'd10, 16'd12, 16'd20
	};

	sched_result_t expected_outcomes [$];
	int            mismatch_count = 0;
	int            cycle_count    = 0;
	int            burst_left     = 0;
	stall_mode_t   stall_mode     = STALL_NONE;
	gap_mode_t     gap_mode       = GAP_NONE;

	multilevel_priority_task_scheduler #(
		.QUEUE_DEPTH (FIFO_DEPTH),
		.ID_WIDTH    (8)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.task_id       (task_id),
		.task_priority (task_priority),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.picked_id     (picked_id),
		.picked_class  (picked_class),
		.slice_ms      (slice_ms),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle counter and run timeout.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver back-pressure, changed on the falling edge.
	always @(negedge clk) begin
		case (stall_mode)
			STALL_RANDOM:  out_stall <= ($urandom_range(0, 99) < 30);
			STALL_PATTERN: out_stall <= STALL_PATTERN_BITS[cycle_count % 16];
			STALL_HEAVY:   out_stall <= ($urandom_range(0, 99) < 75);
			default:       out_stall <= 1'b0;
		endcase
	end

	// Priority number to class, lower numbers being more urgent.
	function automatic int priority_class(input logic [3:0] p);
		case (p)
			4'd0, 4'd1:       return 0;
			4'd2:             return 1;
			4'd3:             return 2;
			4'd4, 4'd5:       return 3;
			4'd6, 4'd7, 4'd8: return 4;
			default:          return 5;
		endcase
	endfunction

	// A random priority number that falls into the given class.
	function automatic logic [3:0] prio_in_class(input int c);
		case (c)
			0:       return 4'($urandom_range(0, 1));
			1:       return 4'd2;
			2:       return 4'd3;
			3:       return 4'($urandom_range(4, 5));
			4:       return 4'($urandom_range(6, 8));
			default: return 4'($urandom_range(9, 15));
		endcase
	endfunction

	// Apply one accepted request beat to the model and queue its result.
	task automatic predict_schedule(input mpts_pkg::opcode_t op, input logic [7:0] id,
			input logic [3:0] prio);
		sched_result_t r;
		int            c;
		bit            found;
		r = '0;
		found = 1'b0;
		case (op)
			mpts_pkg::OP_ENQUEUE, mpts_pkg::OP_BOOST: begin
				c = priority_class(prio);
				if (op == mpts_pkg::OP_BOOST && c > 0)
					c--;
				r.cls = mpts_pkg::cls_t'(c);
				if (fifo_fill[c] >= FIFO_DEPTH) begin
					r.status = mpts_pkg::ST_FULL;
				end else begin
					class_fifo[c][fifo_tail[c]] = id;
					fifo_tail[c] = (fifo_tail[c] + 1) % FIFO_DEPTH;
					fifo_fill[c]++;
					r.status = mpts_pkg::ST_ENQUEUED;
				end
				expected_outcomes.push_back(r);
			end
			mpts_pkg::OP_DISPATCH: begin
				r.status = mpts_pkg::ST_EMPTY;
				for (int k = 0; k < mpts_pkg::NUM_CLASSES; k++) begin
					if (!found && fifo_fill[k] > 0) begin
						r.id = class_fifo[k][fifo_head[k]];
						fifo_head[k] = (fifo_head[k] + 1) % FIFO_DEPTH;
						fifo_fill[k]--;
						r.cls = mpts_pkg::cls_t'(k);
						r.slice = quantum_cfg[k];
						r.status = mpts_pkg::ST_DISPATCHED;
						found = 1'b1;
					end
				end
				expected_outcomes.push_back(r);
			end
			default: begin
				// The unused code leaves the queues alone and yields no result.
			end
		endcase
	endtask

	// Send one request beat, opening a new burst after a random gap.
	task automatic send_item(input mpts_pkg::opcode_t op, input logic [7:0] id,
			input logic [3:0] prio);
		int gap;
		if (burst_left == 0) begin
			gap = (gap_mode == GAP_BURSTY) ? $urandom_range(0, 8) : 0;
			if (gap > 0) begin
				@(negedge clk);
				in_valid      <= 1'b0;
				opcode        <= mpts_pkg::opcode_t'($urandom);
				task_id       <= 8'($urandom);
				task_priority <= 4'($urandom);
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		in_valid      <= 1'b1;
		opcode        <= op;
		task_id       <= id;
		task_priority <= prio;
		do @(posedge clk); while (in_stall !== 1'b0);
		predict_schedule(op, id, prio);
	endtask

	// Lower the request valid and wait until every result beat has arrived.
	task automatic wait_until_drained();
		@(negedge clk) in_valid <= 1'b0;
		burst_left = 0;
		while (expected_outcomes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one configuration register; the block must be idle.
	task automatic write_quantum(input logic [mpts_pkg::CFG_IDX_W-1:0] idx,
			input mpts_pkg::quantum_t value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx < mpts_pkg::NUM_CLASSES)
			quantum_cfg[idx] = value;
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// A push aimed at one class, either direct or through a boost.
	task automatic push_into_class(input int c);
		logic [7:0] id;
		id = 8'($urandom);
		if (c < mpts_pkg::NUM_CLASSES - 1 && $urandom_range(0, 1))
			send_item(mpts_pkg::OP_BOOST, id, prio_in_class(c + 1));
		else if (c == 0 && $urandom_range(0, 1))
			send_item(mpts_pkg::OP_BOOST, id, prio_in_class(0));
		else
			send_item(mpts_pkg::OP_ENQUEUE, id, prio_in_class(c));
	endtask

	// Random requests of every kind with the given share of dispatches.
	task automatic send_random_mix(input int n, input int dispatch_pct);
		int                roll;
		mpts_pkg::opcode_t op;
		repeat (n) begin
			roll = $urandom_range(0, 99);
			if (roll < 4)
				op = OP_UNUSED;
			else if (roll < 4 + dispatch_pct)
				op = mpts_pkg::OP_DISPATCH;
			else if (roll < 4 + dispatch_pct + 20)
				op = mpts_pkg::OP_BOOST;
			else
				op = mpts_pkg::OP_ENQUEUE;
			send_item(op, 8'($urandom), 4'($urandom));
		end
	endtask

	// Compare one result field against its prediction.
	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	// Result checker: every accepted result beat against the oldest prediction.
	always @(posedge clk) begin
		sched_result_t e;
		if (out_valid === 1'b1 && out_stall == 1'b0) begin
			if (expected_outcomes.size() == 0) begin
				$display("%0t: result beat with none expected, status %0h id %0h class %0h",
					$time, status, picked_id, picked_class);
				mismatch_count++;
			end else begin
				e = expected_outcomes.pop_front();
				check_field("status", 16'(e.status), 16'(status));
				check_field("picked_id", 16'(e.id), 16'(picked_id));
				check_field("picked_class", 16'(e.cls), 16'(picked_class));
				check_field("slice_ms", e.slice, slice_ms);
			end
		end
	end

	// Empty dispatch, a push into every class, boosts at both ends, the
	// unused code, then dispatches until the scheduler is empty once more.
	task automatic test_directed_basics();
		gap_mode = GAP_NONE;
		stall_mode = STALL_NONE;
		send_item(mpts_pkg::OP_DISPATCH, 8'hFF, 4'hF);
		send_item(mpts_pkg::OP_ENQUEUE, 8'h00, 4'd0);
		send_item(mpts_pkg::OP_ENQUEUE, 8'hFF, 4'd2);
		send_item(mpts_pkg::OP_ENQUEUE, 8'h5A, 4'd3);
		send_item(mpts_pkg::OP_ENQUEUE, 8'hA5, 4'd5);
		send_item(mpts_pkg::OP_ENQUEUE, 8'h01, 4'd8);
		send_item(mpts_pkg::OP_ENQUEUE, 8'h80, 4'd15);
		send_item(mpts_pkg::OP_BOOST, 8'h7E, 4'd1);
		send_item(mpts_pkg::OP_BOOST, 8'h3C, 4'd9);
		send_item(OP_UNUSED, 8'hFF, 4'hF);
		repeat (9) send_item(mpts_pkg::OP_DISPATCH, 8'h00, 4'h0);
	endtask

	// Mixed traffic under the reset quanta.
	task automatic test_default_quanta_random();
		gap_mode = GAP_BURSTY;
		stall_mode = STALL_RANDOM;
		send_random_mix(75, 35);
		stall_mode = STALL_NONE;
		send_random_mix(75, 35);
	endtask

	// Rounds that overfill one class and then drain the scheduler dry.
	task automatic test_saturation();
		int target;
		int n_push;
		int n_pop;
		gap_mode = GAP_BURSTY;
		for (int round = 0; round < 6; round++) begin
			stall_mode = round[0] ? STALL_HEAVY : STALL_PATTERN;
			target = $urandom_range(0, mpts_pkg::NUM_CLASSES - 1);
			n_push = $urandom_range(FIFO_DEPTH + 2, FIFO_DEPTH + 10);
			repeat (n_push) begin
				if ($urandom_range(0, 9) < 8)
					push_into_class(target);
				else
					send_random_mix(1, 30);
			end
			n_pop = $urandom_range(n_push, n_push + 8);
			repeat (n_pop) send_item(mpts_pkg::OP_DISPATCH, 8'($urandom), 4'($urandom));
		end
	endtask

	// Quanta at zero, at full scale, random and alternating, with writes
	// to the unused indexes that must leave the quanta as they are.
	task automatic test_quantum_settings();
		quanta_set_t        qset;
		mpts_pkg::quantum_t q;
		for (int setting = 0; setting < 4; setting++) begin
			qset = quanta_set_t'(setting);
			wait_until_drained();
			for (int c = 0; c < mpts_pkg::NUM_CLASSES; c++) begin
				case (qset)
					QSET_ZERO:   q = 16'h0000;
					QSET_MAX:    q = 16'hFFFF;
					QSET_RANDOM: q = mpts_pkg::quantum_t'($urandom);
					default:     q = c[0] ? 16'hFFFF : 16'h0000;
				endcase
				write_quantum(REG_QUANTUM_REALTIME + mpts_pkg::CFG_IDX_W'(c), q);
			end
			if (qset == QSET_RANDOM) begin
				write_quantum(REG_RESERVED_LO, mpts_pkg::quantum_t'($urandom));
				write_quantum(REG_RESERVED_HI, mpts_pkg::quantum_t'($urandom));
			end
			gap_mode = GAP_BURSTY;
			stall_mode = stall_mode_t'(setting);
			send_random_mix(100, 30 + 5 * setting);
		end
	endtask

	// Test sequence.
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_directed_basics();
		test_default_quanta_random();
		test_saturation();
		test_quantum_settings();
		wait_until_drained();
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
